// ===== sv/bpi_pkg.sv =====
// Shared constants and types for the bicubic patch interpolator.
package bpi_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int NUM_TAPS        = 4;

  localparam logic [1:0] FIRST_ROW = 2'd0;
  localparam logic [1:0] LAST_ROW  = 2'd3;

  // Per-stage control that travels down the datapath next to the payload.
  typedef struct packed {
    logic       vld;
    logic [1:0] row;
  } ctl_t;

endpackage

// ===== sv/bicubic_patch_interpolator_top.sv =====
// Bicubic 4x4 patch interpolator: row lanes, x accumulation and saturating output.
//
//   channel | ports                                            | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid, in_stall, in_sample_0..3, in_frac_y/x   | input
//   out     | out_valid, out_stall, out_value, out_saturated    | output
//
// One row beat is taken per cycle while in_stall is low; a patch is four beats, frac_x
// is taken on the first. The result register loads once the fourth row beat has passed
// the five-stage weight pipeline, the lane multiply, the merge and the x multiply-add.
// rst_n is synchronous and restarts the row count.
// When a finished patch reaches the end while the previous result is still stalled, the
// whole pipeline freezes and in_stall rises until out_stall drops.
module bicubic_patch_interpolator_top import bpi_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_0,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_1,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_2,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_3,
  input  logic [FRAC_BITS-1:0]          in_frac_y,
  input  logic [FRAC_BITS-1:0]          in_frac_x,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_value,
  output logic                          out_saturated
);

  localparam int SB  = SAMPLE_BITS;
  localparam int F   = FRAC_BITS;
  localparam int WB  = F + 3;
  localparam int PW  = SB + WB;
  localparam int RB  = PW + 2 - F;
  localparam int XW  = WB + RB;
  localparam int AB  = XW + 2;
  localparam int VW  = AB - F;
  localparam int NST = 9;
  localparam int SDD = 5;

  localparam logic signed [AB-1:0] HALF_V = AB'(longint'(1) << (F - 1));
  localparam logic signed [VW-1:0] HI_V   = VW'((longint'(1) << (SB - 1)) - 1);
  localparam logic signed [VW-1:0] LO_V   = VW'(-(longint'(1) << (SB - 1)));

  logic en, accept, load;
  logic out_valid_r, out_valid_nxt;

  ctl_t ctl_r [NST];
  logic [1:0]   row_cnt_r, row_cnt_nxt;
  logic [F-1:0] x_pos_r, x_pos_nxt, tx_c;

  // Only a finished patch that cannot leave holds everything back.
  assign load     = ctl_r[NST-1].vld && (ctl_r[NST-1].row == LAST_ROW);
  assign en       = !(load && out_valid_r && out_stall);
  assign in_stall = !en;
  assign accept   = in_valid && en;

  assign tx_c        = (row_cnt_r == FIRST_ROW) ? in_frac_x : x_pos_r;
  assign row_cnt_nxt = accept ? row_cnt_r + 2'd1 : row_cnt_r;
  assign x_pos_nxt   = (accept && row_cnt_r == FIRST_ROW) ? in_frac_x : x_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= FIRST_ROW;
      x_pos_r   <= '0;
      for (int i = 0; i < NST; i++) begin
        ctl_r[i] <= '0;
      end
    end else begin
      row_cnt_r <= row_cnt_nxt;
      x_pos_r   <= x_pos_nxt;
      if (en) begin
        ctl_r[0] <= '{vld: in_valid, row: row_cnt_r};
        for (int i = 1; i < NST; i++) begin
          ctl_r[i] <= ctl_r[i-1];
        end
      end
    end
  end

  // Samples wait here while the weights are worked out.
  logic signed [SB-1:0] sd_r [SDD][NUM_TAPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0][0] <= in_sample_0;
      sd_r[0][1] <= in_sample_1;
      sd_r[0][2] <= in_sample_2;
      sd_r[0][3] <= in_sample_3;
      for (int i = 1; i < SDD; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  logic signed [WB-1:0] wy [NUM_TAPS];
  logic signed [WB-1:0] wx [NUM_TAPS];

  bpi_weights #(.F(F), .WB(WB)) u_wy (
    .clk (clk),
    .en  (en),
    .t_i (in_frac_y),
    .w_o (wy)
  );

  bpi_weights #(.F(F), .WB(WB)) u_wx (
    .clk (clk),
    .en  (en),
    .t_i (tx_c),
    .w_o (wx)
  );

  logic signed [PW-1:0] prod [NUM_TAPS];

  for (genvar g = 0; g < NUM_TAPS; g++) begin : g_lane
    bpi_lane #(.SB(SB), .WB(WB)) u_lane (
      .clk    (clk),
      .en     (en),
      .w_i    (wy[g]),
      .s_i    (sd_r[SDD-1][g]),
      .prod_o (prod[g])
    );
  end

  logic signed [RB-1:0] row_res;

  bpi_merge #(.F(F), .PW(PW)) u_merge (
    .clk    (clk),
    .en     (en),
    .prod_i (prod),
    .row_o  (row_res)
  );

  // The x weight for this row follows the row result down the pipeline.
  logic signed [WB-1:0] wx_s_r, wx_d_r;
  logic signed [XW-1:0] xprod_c, xprod_r;
  logic signed [AB-1:0] acc_r, acc_nxt, acc_base_c;

  assign xprod_c    = wx_d_r * row_res;
  assign acc_base_c = (ctl_r[NST-2].row == FIRST_ROW) ? '0 : acc_r;
  assign acc_nxt    = (en && ctl_r[NST-2].vld) ? acc_base_c + AB'(xprod_r) : acc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      wx_s_r  <= wx[ctl_r[SDD-1].row];
      wx_d_r  <= wx_s_r;
      xprod_r <= xprod_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // Output register with rounding and clipping to the sample range.
  logic signed [AB-1:0] acc_rnd_c;
  logic signed [VW-1:0] v_c;
  logic                 sat_hi_c, sat_lo_c;
  logic signed [SB-1:0] out_value_r;
  logic                 out_sat_r;

  assign acc_rnd_c = acc_r + HALF_V;
  assign v_c       = acc_rnd_c[AB-1:F];
  assign sat_hi_c  = v_c > HI_V;
  assign sat_lo_c  = v_c < LO_V;

  assign out_valid_nxt = (load && en) ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && en) begin
      out_sat_r <= sat_hi_c || sat_lo_c;
      if (sat_hi_c) begin
        out_value_r <= HI_V[SB-1:0];
      end else if (sat_lo_c) begin
        out_value_r <= LO_V[SB-1:0];
      end else begin
        out_value_r <= v_c[SB-1:0];
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && row_cnt_r == LAST_ROW) |=> (row_cnt_r == FIRST_ROW))
    else $error("row count did not wrap after the last row beat");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(load && en))
    else $error("result appeared without a finished patch");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (load && en) |=> out_valid_r)
    else $error("finished patch was not registered at the output");

  a_freeze_acc: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(acc_r))
    else $error("accumulator moved while the pipeline was frozen");

endmodule

// ===== sv/bpi_weights.sv =====
// Five-stage pipeline that turns a Q0.F fraction into four cubic Lagrange weights.
module bpi_weights import bpi_pkg::*; #(
  parameter int F  = FRAC_BITS_DEF,
  parameter int WB = FRAC_BITS_DEF + 3
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [F-1:0]         t_i,
  output logic signed [WB-1:0] w_o [NUM_TAPS]
);

  localparam int K = F + 5;
  localparam logic [F:0]     ONE_V   = (F+1)'(1) << F;
  localparam logic [F+1:0]   TWO_V   = (F+2)'(1) << (F + 1);
  localparam logic [2*F+1:0] THREE_V = (2*F+2)'(3) << F;
  localparam logic [2*F+2:0] RND_W0  = (2*F+3)'(1) << F;
  localparam logic [F+2:0]   RECIP   = (F+3)'((longint'(1) << K) / 6);
  localparam logic [F+1:0]   SIX_V   = (F+2)'(6);

  // Stage 1: a = t(1-t), b = (1+t)(1-t).
  logic [F:0]     u_c, s_c;
  logic [2*F+1:0] pa_c, pb_c;
  logic [F-1:0]   t1_r, a1_r;
  logic [F:0]     b1_r;

  assign u_c  = ONE_V - (F+1)'(t_i);
  assign s_c  = ONE_V + (F+1)'(t_i);
  assign pa_c = (2*F+2)'(t_i) * (2*F+2)'(u_c);
  assign pb_c = (2*F+2)'(s_c) * (2*F+2)'(u_c);

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= t_i;
      a1_r <= pa_c[2*F-1:F];
      b1_r <= pb_c[2*F:F];
    end
  end

  // Stage 2: scaled numerators; the weight at zero needs only a shift.
  logic [F+1:0]   v2_c;
  logic [F:0]     s2_c;
  logic [2*F+1:0] xm_c, xp_c;
  logic [2*F+2:0] xw_c;
  logic [2*F+1:0] qm_c, qp_c;
  logic [2*F+2:0] w0_c;
  logic [F+1:0]   qm2_r, qp2_r, w02_r;

  assign v2_c = TWO_V - (F+2)'(t1_r);
  assign s2_c = ONE_V + (F+1)'(t1_r);
  assign xm_c = (2*F+2)'(a1_r) * (2*F+2)'(v2_c);
  assign xp_c = (2*F+2)'(a1_r) * (2*F+2)'(s2_c);
  assign xw_c = (2*F+3)'(b1_r) * (2*F+3)'(v2_c);
  assign qm_c = xm_c + THREE_V;
  assign qp_c = xp_c + THREE_V;
  assign w0_c = xw_c + RND_W0;

  always_ff @(posedge clk) begin
    if (en) begin
      qm2_r <= qm_c[2*F+1:F];
      qp2_r <= qp_c[2*F+1:F];
      w02_r <= w0_c[2*F+2:F+1];
    end
  end

  // Stage 3: quotient estimate by six through a reciprocal; it is low by at most one.
  logic [2*F+4:0] em_c, ep_c;
  logic [F-1:0]   em3_r, ep3_r;
  logic [F+1:0]   qm3_r, qp3_r, w03_r;

  assign em_c = (2*F+5)'(qm2_r) * (2*F+5)'(RECIP);
  assign ep_c = (2*F+5)'(qp2_r) * (2*F+5)'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      em3_r <= em_c[K+F-1:K];
      ep3_r <= ep_c[K+F-1:K];
      qm3_r <= qm2_r;
      qp3_r <= qp2_r;
      w03_r <= w02_r;
    end
  end

  // Stage 4: correct the estimate from the remainder.
  logic [F+1:0] rm_c, rp_c;
  logic [F-1:0] m4_r, p4_r;
  logic [F+1:0] w04_r;

  assign rm_c = qm3_r - {em3_r, 2'b00} - {1'b0, em3_r, 1'b0};
  assign rp_c = qp3_r - {ep3_r, 2'b00} - {1'b0, ep3_r, 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      m4_r  <= em3_r + F'(rm_c >= SIX_V);
      p4_r  <= ep3_r + F'(rp_c >= SIX_V);
      w04_r <= w03_r;
    end
  end

  // Stage 5: the weight at +1 makes the four weights sum to one.
  logic signed [WB-1:0] sm_c, sp_c, sw0_c;
  logic signed [WB-1:0] w_r [NUM_TAPS];

  assign sm_c  = WB'(m4_r);
  assign sp_c  = WB'(p4_r);
  assign sw0_c = WB'(w04_r);

  always_ff @(posedge clk) begin
    if (en) begin
      w_r[0] <= -sm_c;
      w_r[1] <= sw0_c;
      w_r[2] <= WB'(ONE_V) + sm_c + sp_c - sw0_c;
      w_r[3] <= -sp_c;
    end
  end

  assign w_o = w_r;

endmodule

// ===== sv/bpi_lane.sv =====
// One multiply lane: weight times sample, registered.
module bpi_lane import bpi_pkg::*; #(
  parameter int SB = SAMPLE_BITS_DEF,
  parameter int WB = FRAC_BITS_DEF + 3
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WB-1:0]    w_i,
  input  logic signed [SB-1:0]    s_i,
  output logic signed [SB+WB-1:0] prod_o
);

  logic signed [SB+WB-1:0] prod_c, prod_r;

  assign prod_c = w_i * s_i;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_c;
    end
  end

  assign prod_o = prod_r;

endmodule

// ===== sv/bpi_merge.sv =====
// Adds the four lane products and rounds the row result back to sample scale.
module bpi_merge import bpi_pkg::*; #(
  parameter int F  = FRAC_BITS_DEF,
  parameter int PW = SAMPLE_BITS_DEF + FRAC_BITS_DEF + 3
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [PW-1:0]    prod_i [NUM_TAPS],
  output logic signed [PW+1-F:0]  row_o
);

  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] HALF_V = SW'(longint'(1) << (F - 1));

  logic signed [SW-1:0]   sum_c, rnd_c;
  logic signed [SW-F-1:0] row_r;

  assign sum_c = SW'(prod_i[0]) + SW'(prod_i[1]) + SW'(prod_i[2]) + SW'(prod_i[3]);
  assign rnd_c = sum_c + HALF_V;

  // With half added first, dropping the low bits rounds to nearest, ties upward.
  always_ff @(posedge clk) begin
    if (en) begin
      row_r <= rnd_c[SW-1:F];
    end
  end

  assign row_o = row_r;

endmodule

// ===== sim/bicubic_patch_interpolator_top_tb.sv =====
// Self-checking testbench for the bicubic 4x4 patch interpolator.

typedef logic signed [bpi_pkg::SAMPLE_BITS_DEF-1:0] sample_t;
typedef logic [bpi_pkg::FRAC_BITS_DEF-1:0] frac_t;

typedef struct {
  sample_t sample [bpi_pkg::NUM_TAPS];
  frac_t   frac_y;
  frac_t   frac_x;
} patch_row_t;

typedef struct {
  sample_t value;
  logic    saturated;
} pixel_t;

class patch_scoreboard;
  bit [1:0] row_idx;
  frac_t    x_frac;
  longint   x_acc;
  pixel_t   predicted_pixels[$];
  int       errors;
  int       rows_taken;
  int       pixels_checked;
  int       pixels_clipped;

  // Cubic Lagrange taps for points -1, 0, +1, +2 at fraction t.
  function void lagrange_taps(input frac_t t, output longint w [bpi_pkg::NUM_TAPS]);
    longint unsigned one, tt, a, m, p, b, w0;
    one = 64'd1 << bpi_pkg::FRAC_BITS_DEF;
    tt  = t;
    a   = (tt * (one - tt)) >> bpi_pkg::FRAC_BITS_DEF;
    m   = (a * (2 * one - tt) + 3 * one) / (6 * one);
    p   = (a * (one + tt) + 3 * one) / (6 * one);
    b   = ((one + tt) * (one - tt)) >> bpi_pkg::FRAC_BITS_DEF;
    w0  = (b * (2 * one - tt) + one) / (2 * one);
    w[0] = -longint'(m);
    w[1] = longint'(w0);
    w[2] = longint'(one) + longint'(m) + longint'(p) - longint'(w0);
    w[3] = -longint'(p);
  endfunction

  function void note_row(patch_row_t r);
    longint wy [bpi_pkg::NUM_TAPS];
    longint wx [bpi_pkg::NUM_TAPS];
    longint half, hi, lo, sum, row_val, v;
    pixel_t px;
    int k;
    half = longint'(1) << (bpi_pkg::FRAC_BITS_DEF - 1);
    hi   = (longint'(1) << (bpi_pkg::SAMPLE_BITS_DEF - 1)) - 1;
    lo   = -(longint'(1) << (bpi_pkg::SAMPLE_BITS_DEF - 1));
    rows_taken++;
    if (row_idx == bpi_pkg::FIRST_ROW) begin
      x_frac = r.frac_x;
      x_acc  = 0;
    end
    lagrange_taps(r.frac_y, wy);
    sum = 0;
    for (k = 0; k < bpi_pkg::NUM_TAPS; k++) begin
      sum += wy[k] * longint'(r.sample[k]);
    end
    // The row result keeps its full range; only the final pixel is clipped.
    row_val = (sum + half) >>> bpi_pkg::FRAC_BITS_DEF;
    lagrange_taps(x_frac, wx);
    x_acc += wx[row_idx] * row_val;
    if (row_idx != bpi_pkg::LAST_ROW) begin
      row_idx++;
    end else begin
      v = (x_acc + half) >>> bpi_pkg::FRAC_BITS_DEF;
      px.saturated = 1'b0;
      if (v > hi) begin
        v = hi;
        px.saturated = 1'b1;
      end
      if (v < lo) begin
        v = lo;
        px.saturated = 1'b1;
      end
      px.value = sample_t'(v);
      predicted_pixels.push_back(px);
      row_idx = bpi_pkg::FIRST_ROW;
      x_acc   = 0;
    end
  endfunction

  function void check_pixel(sample_t got_value, logic got_sat);
    pixel_t want;
    pixels_checked++;
    if (predicted_pixels.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("Unexpected result beat: value %0d saturated %b", got_value, got_sat);
    end else begin
      want = predicted_pixels.pop_front();
      if (want.saturated) pixels_clipped++;
      if (got_value !== want.value || got_sat !== want.saturated) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch on result %0d: expected value %0d saturated %b, got value %0d saturated %b",
                   pixels_checked, want.value, want.saturated, got_value, got_sat);
      end
    end
  endfunction

  function int pending();
    return predicted_pixels.size();
  endfunction
endclass

module bicubic_patch_interpolator_top_tb;
  localparam int CYCLE_LIMIT       = 400000;
  localparam int PATCHES_PER_PHASE = 108;
  localparam sample_t S_MAX = {1'b0, {(bpi_pkg::SAMPLE_BITS_DEF-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(bpi_pkg::SAMPLE_BITS_DEF-1){1'b0}}};

  logic    clk;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t in_sample_0 = '0;
  sample_t in_sample_1 = '0;
  sample_t in_sample_2 = '0;
  sample_t in_sample_3 = '0;
  frac_t   in_frac_y = '0;
  frac_t   in_frac_x = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sample_t out_value;
  logic    out_saturated;

  int send_idle_pct = 20;
  int recv_idle_pct = 62;
  int cycle_count = 0;

  patch_scoreboard sb = new();

  bicubic_patch_interpolator_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_0  (in_sample_0),
    .in_sample_1  (in_sample_1),
    .in_sample_2  (in_sample_2),
    .in_sample_3  (in_sample_3),
    .in_frac_y    (in_frac_y),
    .in_frac_x    (in_frac_x),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_saturated(out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_pixel(out_value, out_saturated);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic patch_row_t make_row(sample_t s0, sample_t s1, sample_t s2, sample_t s3,
                                          frac_t fy, frac_t fx);
    patch_row_t r;
    r.sample[0] = s0;
    r.sample[1] = s1;
    r.sample[2] = s2;
    r.sample[3] = s3;
    r.frac_y    = fy;
    r.frac_x    = fx;
    return r;
  endfunction

  // Extremes are favored so that clipped pixels show up in the random part too.
  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic frac_t rand_frac();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return frac_t'($urandom());
    endcase
  endfunction

  task automatic send_row(patch_row_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_sample_0 <= r.sample[0];
    in_sample_1 <= r.sample[1];
    in_sample_2 <= r.sample[2];
    in_sample_3 <= r.sample[3];
    in_frac_y   <= r.frac_y;
    in_frac_x   <= r.frac_x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_row(r);
  endtask

  // frac_x only matters on the first row, so later rows carry noise there.
  task automatic send_random_patches(int count);
    patch_row_t r;
    frac_t fx;
    int i, j;
    for (i = 0; i < count; i++) begin
      fx = rand_frac();
      for (j = 0; j < bpi_pkg::NUM_TAPS; j++) begin
        r = make_row(rand_sample(), rand_sample(), rand_sample(), rand_sample(), rand_frac(),
                     (j == 0) ? fx : frac_t'($urandom()));
        send_row(r);
      end
    end
  endtask

  initial begin
    patch_row_t directed[$];
    int k;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Zero patch at zero fractions.
    for (k = 0; k < 4; k++) directed.push_back(make_row('0, '0, '0, '0, '0, '0));
    // Zero fractions pass through sample 1 of row 1; frac_x on later rows must be ignored.
    directed.push_back(make_row(S_MAX, S_MIN, S_MAX, S_MIN, '0, '0));
    directed.push_back(make_row(S_MIN, 24'sd1234567, S_MIN, S_MAX, '0, '1));
    directed.push_back(make_row(S_MAX, S_MAX, S_MIN, S_MIN, '0, '1));
    directed.push_back(make_row(24'sd1, -24'sd1, 24'sd1, -24'sd1, '0, '1));
    // Top fractions, with frac_y changing from row to row.
    directed.push_back(make_row(S_MIN, S_MIN, S_MIN, S_MIN, '1, '1));
    directed.push_back(make_row(S_MIN, S_MAX, S_MIN, S_MAX, '0, '0));
    directed.push_back(make_row(S_MAX, S_MIN, S_MIN, S_MAX, 16'h8000, 16'h1234));
    directed.push_back(make_row(S_MIN, S_MIN, S_MAX, S_MIN, 16'h0001, '0));
    // Overshoot in both directions drives the clip high, then low.
    directed.push_back(make_row(S_MAX, S_MIN, S_MIN, S_MAX, 16'h8000, 16'h8000));
    directed.push_back(make_row(S_MIN, S_MAX, S_MAX, S_MIN, 16'h8000, 16'h8000));
    directed.push_back(make_row(S_MIN, S_MAX, S_MAX, S_MIN, 16'h8000, 16'h8000));
    directed.push_back(make_row(S_MAX, S_MIN, S_MIN, S_MAX, 16'h8000, 16'h8000));
    directed.push_back(make_row(S_MIN, S_MAX, S_MAX, S_MIN, 16'h8000, 16'h8000));
    directed.push_back(make_row(S_MAX, S_MIN, S_MIN, S_MAX, 16'h8000, 16'h8000));
    directed.push_back(make_row(S_MAX, S_MIN, S_MIN, S_MAX, 16'h8000, 16'h8000));
    directed.push_back(make_row(S_MIN, S_MAX, S_MAX, S_MIN, 16'h8000, 16'h8000));
    // Alternating bit patterns on every field.
    directed.push_back(make_row(24'sh555555, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA,
                                16'h5555, 16'hAAAA));
    directed.push_back(make_row(24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 24'sh555555,
                                16'hAAAA, 16'h5555));
    directed.push_back(make_row(24'sh555555, 24'sh555555, 24'shAAAAAA, 24'shAAAAAA,
                                16'h5555, 16'h5555));
    directed.push_back(make_row(24'shAAAAAA, 24'shAAAAAA, 24'sh555555, 24'sh555555,
                                16'hAAAA, 16'hAAAA));
    for (k = 0; k < directed.size(); k++) send_row(directed[k]);

    send_random_patches(PATCHES_PER_PHASE);
    send_idle_pct = 62;
    recv_idle_pct = 20;
    send_random_patches(PATCHES_PER_PHASE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_patches(PATCHES_PER_PHASE);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    // Leave room for any stray result beat still in the pipeline.
    repeat (20) @(posedge clk);

    $display("Covered %0d row beats in %0d patches under three stall and idle mixes.",
             sb.rows_taken, sb.rows_taken / 4);
    $display("Checked %0d result beats, %0d of them clipped; %0d mismatches.",
             sb.pixels_checked, sb.pixels_clipped, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
